FILE: rtl/rssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssd_pkg
// Shared widths, command, status and register index codes for the
// run-length shaded sprite decoder.
// ----------------------------------------------------------------------------
package rssd_pkg;

    localparam int COUNT_BITS = 32;

    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int COLOR_W  = 16;
    localparam int SHADE_W  = 5;
    localparam int DIM_W    = 8;
    localparam int POS_W    = 16;
    localparam int SCREEN_W = 15;
    localparam int SUM_W    = 18;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_FEED  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START = 2'd2;

    localparam logic [STATUS_W-1:0] ST_VISIBLE   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CROPPED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NEED_DATA = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DATA_END  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TAKEN     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_REFUSED   = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_COLOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POS_X         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd6;

    localparam logic [COLOR_W-1:0]  BASE_COLOR_RST    = 16'hffff;
    localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 15'd320;
    localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 15'd240;

endpackage

FILE: rtl/rssd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssd_req_if / rssd_rsp_if
// Valid/ready channels carrying command words in and status words out.
// ----------------------------------------------------------------------------
interface rssd_req_if;
    logic                          valid;
    logic                          ready;
    logic [rssd_pkg::CMD_W-1:0]    command;
    logic [rssd_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface rssd_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [rssd_pkg::STATUS_W-1:0]   status;
    logic [rssd_pkg::COLOR_W-1:0]    pixel_color;

    modport source (output valid, output status, output pixel_color, input ready);
    modport sink   (input valid, input status, input pixel_color, output ready);
endinterface

FILE: rtl/rle_shaded_sprite_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_shaded_sprite_decoder
// The status word is registered and appears in the cycle after its command word is taken.
// Throughput: one command word per cycle; the output register is refilled in
// the same cycle that its word is taken, so only a stalled sink holds input.
// Reset (async, active low) clears decode state and loads register defaults.
// ----------------------------------------------------------------------------
module rle_shaded_sprite_decoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rssd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rssd_pkg::CFG_DATA_W-1:0]     cfg_data,
    rssd_req_if.sink                            req,
    rssd_rsp_if.source                          rsp
);

    localparam int CB = rssd_pkg::COUNT_BITS;

    // configuration registers
    logic [rssd_pkg::COLOR_W-1:0]        base_color_reg;
    logic [rssd_pkg::DIM_W-1:0]          image_width_reg;
    logic [rssd_pkg::DIM_W-1:0]          image_height_reg;
    logic signed [rssd_pkg::POS_W-1:0]   pos_x_reg;
    logic signed [rssd_pkg::POS_W-1:0]   pos_y_reg;
    logic [rssd_pkg::SCREEN_W-1:0]       screen_width_reg;
    logic [rssd_pkg::SCREEN_W-1:0]       screen_height_reg;

    // decode state
    logic [CB-1:0]                       count_accum_reg, count_accum_next;
    logic [CB-1:0]                       run_left_reg, run_left_next;
    logic [rssd_pkg::SHADE_W-1:0]        run_shade_reg, run_shade_next;
    logic [rssd_pkg::DIM_W-1:0]          row_pos_reg, row_pos_next;
    logic [rssd_pkg::DIM_W-1:0]          col_pos_reg, col_pos_next;
    logic                                error_flag_reg, error_flag_next;
    logic                                mid_code_reg, mid_code_next;
    logic                                end_seen_reg, end_seen_next;

    // output register
    logic                                out_valid_reg;
    logic [rssd_pkg::STATUS_W-1:0]       out_status_reg, out_status_next;
    logic [rssd_pkg::COLOR_W-1:0]        out_color_reg, out_color_next;

    logic                                accept;
    logic [rssd_pkg::COLOR_W-1:0]        shaded_color;

    // geometry
    logic signed [rssd_pkg::SUM_W-1:0]   px_ext, py_ext, sw_ext, sh_ext;
    logic signed [rssd_pkg::SUM_W-1:0]   w_ext, h_ext, col_ext, row_ext;
    logic signed [rssd_pkg::SUM_W-1:0]   col_scr, row_scr, px_end, py_end;
    logic                                nothing_to_draw;
    logic                                done_now;
    logic                                visible;
    logic                                col_wrap;

    assign req.ready       = !out_valid_reg || rsp.ready;
    assign accept          = req.valid && req.ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.pixel_color = out_color_reg;

    rssd_shade u_shade
    (
        .base_color (base_color_reg),
        .shade      (run_shade_reg),
        .color      (shaded_color)
    );

    always_comb
    begin
        px_ext  = rssd_pkg::SUM_W'(pos_x_reg);
        py_ext  = rssd_pkg::SUM_W'(pos_y_reg);
        sw_ext  = signed'({3'd0, screen_width_reg});
        sh_ext  = signed'({3'd0, screen_height_reg});
        w_ext   = signed'({10'd0, image_width_reg});
        h_ext   = signed'({10'd0, image_height_reg});
        col_ext = signed'({10'd0, col_pos_reg});
        row_ext = signed'({10'd0, row_pos_reg});
        col_scr = px_ext + col_ext;
        row_scr = py_ext + row_ext;
        px_end  = px_ext + w_ext;
        py_end  = py_ext + h_ext;

        nothing_to_draw = (image_width_reg == '0) || (image_height_reg == '0) ||
                          (px_ext >= sw_ext) || (py_ext >= sh_ext) ||
                          (px_end < 0) || (py_end < 0);
        done_now = nothing_to_draw || (row_pos_reg >= image_height_reg) ||
                   (row_scr >= sh_ext);
        visible  = (row_scr >= 0) && (col_scr >= 0) &&
                   (col_pos_reg < image_width_reg) && (col_scr < sw_ext);
        col_wrap = ({1'b0, col_pos_reg} + 9'd1) >= {1'b0, image_width_reg};
    end

    always_comb
    begin
        count_accum_next = count_accum_reg;
        run_left_next    = run_left_reg;
        run_shade_next   = run_shade_reg;
        row_pos_next     = row_pos_reg;
        col_pos_next     = col_pos_reg;
        error_flag_next  = error_flag_reg;
        mid_code_next    = mid_code_reg;
        end_seen_next    = end_seen_reg;
        out_status_next  = rssd_pkg::ST_REFUSED;
        out_color_next   = '0;

        case (req.command)
            rssd_pkg::CMD_START:
            begin
                count_accum_next = '0;
                run_left_next    = '0;
                run_shade_next   = '0;
                row_pos_next     = '0;
                col_pos_next     = '0;
                error_flag_next  = 1'b0;
                mid_code_next    = 1'b0;
                end_seen_next    = 1'b0;
                // row and column restart at zero, so only the size and screen-bounds test remains
                out_status_next  = nothing_to_draw ? rssd_pkg::ST_DONE
                                                   : rssd_pkg::ST_NEED_DATA;
            end
            rssd_pkg::CMD_FEED:
            begin
                if (run_left_reg != '0 || end_seen_reg || error_flag_reg)
                begin
                    out_status_next = rssd_pkg::ST_REFUSED;
                end
                else if (!mid_code_reg && req.data_byte == '0)
                begin
                    end_seen_next   = 1'b1;
                    out_status_next = rssd_pkg::ST_TAKEN;
                end
                else if (req.data_byte[7])
                begin
                    count_accum_next = {count_accum_reg[CB-8:0], req.data_byte[6:0]};
                    mid_code_next    = 1'b1;
                    out_status_next  = rssd_pkg::ST_TAKEN;
                end
                else
                begin
                    run_left_next    = {count_accum_reg[CB-3:0], req.data_byte[6:5]};
                    run_shade_next   = req.data_byte[4:0];
                    count_accum_next = '0;
                    mid_code_next    = 1'b0;
                    out_status_next  = rssd_pkg::ST_TAKEN;
                end
            end
            rssd_pkg::CMD_PIXEL:
            begin
                if (error_flag_reg)
                begin
                    out_status_next = rssd_pkg::ST_DATA_END;
                end
                else if (done_now)
                begin
                    out_status_next = rssd_pkg::ST_DONE;
                end
                else if (run_left_reg == '0)
                begin
                    if (end_seen_reg)
                    begin
                        error_flag_next = 1'b1;
                        out_status_next = rssd_pkg::ST_DATA_END;
                    end
                    else
                    begin
                        out_status_next = rssd_pkg::ST_NEED_DATA;
                    end
                end
                else
                begin
                    run_left_next = run_left_reg - 1'b1;
                    if (visible)
                    begin
                        out_status_next = rssd_pkg::ST_VISIBLE;
                        out_color_next  = shaded_color;
                    end
                    else
                    begin
                        out_status_next = rssd_pkg::ST_CROPPED;
                    end
                    if (col_wrap)
                    begin
                        col_pos_next = '0;
                        row_pos_next = row_pos_reg + 1'b1;
                    end
                    else
                    begin
                        col_pos_next = col_pos_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                out_status_next = rssd_pkg::ST_REFUSED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_color_reg    <= rssd_pkg::BASE_COLOR_RST;
            image_width_reg   <= '0;
            image_height_reg  <= '0;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            screen_width_reg  <= rssd_pkg::SCREEN_WIDTH_RST;
            screen_height_reg <= rssd_pkg::SCREEN_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rssd_pkg::REG_BASE_COLOR:    base_color_reg    <= cfg_data;
                rssd_pkg::REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[7:0];
                rssd_pkg::REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[7:0];
                rssd_pkg::REG_POS_X:         pos_x_reg         <= signed'(cfg_data);
                rssd_pkg::REG_POS_Y:         pos_y_reg         <= signed'(cfg_data);
                rssd_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[14:0];
                rssd_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[14:0];
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_accum_reg <= '0;
            run_left_reg    <= '0;
            run_shade_reg   <= '0;
            row_pos_reg     <= '0;
            col_pos_reg     <= '0;
            error_flag_reg  <= 1'b0;
            mid_code_reg    <= 1'b0;
            end_seen_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_accum_reg <= count_accum_next;
                run_left_reg    <= run_left_next;
                run_shade_reg   <= run_shade_next;
                row_pos_reg     <= row_pos_next;
                col_pos_reg     <= col_pos_next;
                error_flag_reg  <= error_flag_next;
                mid_code_reg    <= mid_code_next;
                end_seen_reg    <= end_seen_next;
                out_valid_reg   <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_status_reg <= out_status_next;
            out_color_reg  <= out_color_next;
        end
    end

    // a loaded run never coexists with a half-built count
    a_run_not_mid: assert property (@(posedge clk) disable iff (!rst_n)
        run_left_reg != '0 |-> !mid_code_reg)
        else $error("run pending while count code is open");

    // data end error only follows the end marker
    a_error_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        error_flag_reg |-> end_seen_reg)
        else $error("error flag without end marker");

    // color only carried by visible pixels
    a_color_visible_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != rssd_pkg::ST_VISIBLE |-> rsp.pixel_color == '0)
        else $error("color on non-visible word");

    // bytes refused after an error
    a_refuse_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.command == rssd_pkg::CMD_FEED && error_flag_reg
        |=> rsp.valid && rsp.status == rssd_pkg::ST_REFUSED)
        else $error("byte taken after data end error");

endmodule

FILE: rtl/rssd_shade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssd_shade
// Scales each RGB565 channel by shade/31, rounding down.
// ----------------------------------------------------------------------------
module rssd_shade
(
    input  logic [rssd_pkg::COLOR_W-1:0] base_color,
    input  logic [rssd_pkg::SHADE_W-1:0] shade,
    output logic [rssd_pkg::COLOR_W-1:0] color
);

    // floor(x / 31) for x below 1984: x * 2115 >> 16
    function automatic logic [5:0] div31(input logic [10:0] x);
        logic [22:0] prod;
        prod = {12'd0, x} + {11'd0, x, 1'b0} + {6'd0, x, 6'd0} + {1'b0, x, 11'd0};
        return prod[21:16];
    endfunction

    logic [9:0]  r_prod;
    logic [10:0] g_prod;
    logic [9:0]  b_prod;
    logic [5:0]  r_q;
    logic [5:0]  g_q;
    logic [5:0]  b_q;

    always_comb
    begin
        r_prod = base_color[15:11] * shade;
        g_prod = base_color[10:5] * shade;
        b_prod = base_color[4:0] * shade;
        r_q    = div31({1'b0, r_prod});
        g_q    = div31(g_prod);
        b_q    = div31({1'b0, b_prod});
        color  = {r_q[4:0], g_q, b_q[4:0]};
    end

endmodule
